// ===== rtl/closed_tour_length_defines.svh =====
// Assertion macros used by the controller RTL of the closed tour length block.
`ifndef CLOSED_TOUR_LENGTH_DEFINES_SVH
`define CLOSED_TOUR_LENGTH_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define CTL_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define CTL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ctl_pkg.sv =====
package ctl_pkg;

   // Field widths.
   localparam int CoordBits = 16;
   localparam int TotalBits = 32;

   // Square root datapath sizing: the radicand is the sum of two squares.
   localparam int RootBits = CoordBits + 1;
   localparam int RadBits  = 2 * RootBits;
   localparam int RemBits  = RootBits + 2;
   localparam int StepBits = $clog2(RootBits);

   typedef struct packed {
      logic signed [CoordBits-1:0] city_x;
      logic signed [CoordBits-1:0] city_y;
      logic                        last_city;
   } req_type;

   typedef struct packed {
      logic [TotalBits-1:0] tour_length;
      logic                 length_saturated;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIFF,
      ST_SQUARE,
      ST_SUM,
      ST_ROOT,
      ST_ACCUM,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_city;
      logic diff_en;
      logic close_sel;
      logic square_en;
      logic sum_en;
      logic root_step;
      logic accum_en;
      logic out_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic have_first;
      logic last_city;
   } sts_type;

endpackage

// ===== rtl/ctl_dpath.sv =====
module ctl_dpath (
   input  logic             clock,
   input  logic             reset,
   input  ctl_pkg::req_type req_data,
   input  ctl_pkg::cmd_type cmd,
   output ctl_pkg::sts_type sts,
   output ctl_pkg::rsp_type rsp_data
);

   localparam int C = ctl_pkg::CoordBits;
   localparam int T = ctl_pkg::TotalBits;
   localparam int R = ctl_pkg::RootBits;
   localparam int W = ctl_pkg::RadBits;
   localparam int M = ctl_pkg::RemBits;

   logic signed [C-1:0] cur_x_ff, cur_y_ff;
   logic                last_ff;
   logic signed [C-1:0] first_x_ff, first_y_ff;
   logic signed [C-1:0] prev_x_ff, prev_y_ff;
   logic                have_first_ff;
   logic [T-1:0]        total_ff, total_in;
   logic                sat_ff, sat_in;
   logic [C-1:0]        dx_ff, dy_ff, dx_in, dy_in;
   logic [2*C-1:0]      sx_ff, sy_ff;
   logic [W-1:0]        rad_ff, rad_in;
   logic [M-1:0]        rem_ff, rem_in;
   logic [R-1:0]        root_ff, root_in;
   ctl_pkg::rsp_type    rsp_ff;

   logic signed [C-1:0] op_ax, op_ay, op_bx, op_by;
   logic signed [C:0]   diff_x, diff_y;
   logic [C:0]          mag_x, mag_y;
   logic [M-1:0]        rem_shift, trial;
   logic [T:0]          sum_wide;

   // Edge operands: previous to current city, or current back to first.
   always_comb begin
      if (cmd.close_sel) begin
         op_ax = cur_x_ff;
         op_ay = cur_y_ff;
         op_bx = first_x_ff;
         op_by = first_y_ff;
      end else begin
         op_ax = prev_x_ff;
         op_ay = prev_y_ff;
         op_bx = cur_x_ff;
         op_by = cur_y_ff;
      end
   end

   // Absolute coordinate differences, one bit wider before the magnitude.
   always_comb begin
      diff_x = {op_ax[C-1], op_ax} - {op_bx[C-1], op_bx};
      diff_y = {op_ay[C-1], op_ay} - {op_by[C-1], op_by};
      mag_x  = diff_x[C] ? (C+1)'(-diff_x) : (C+1)'(diff_x);
      mag_y  = diff_y[C] ? (C+1)'(-diff_y) : (C+1)'(diff_y);
      dx_in  = mag_x[C-1:0];
      dy_in  = mag_y[C-1:0];
   end

   // One restoring square root step: bring down two radicand bits per cycle.
   always_comb begin
      rem_shift = {rem_ff[M-3:0], rad_ff[W-1 -: 2]};
      trial     = {root_ff, 2'b01};
      rad_in    = {rad_ff[W-3:0], 2'b00};
      if (rem_shift >= trial) begin
         rem_in  = rem_shift - trial;
         root_in = {root_ff[R-2:0], 1'b1};
      end else begin
         rem_in  = rem_shift;
         root_in = {root_ff[R-2:0], 1'b0};
      end
   end

   // Saturating add of the finished edge length to the tour total.
   always_comb begin
      sum_wide = {1'b0, total_ff} + (T+1)'(root_ff);
      if (sum_wide[T]) begin
         total_in = '1;
         sat_in   = 1'b1;
      end else begin
         total_in = sum_wide[T-1:0];
         sat_in   = sat_ff;
      end
   end

   // Tour state with reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         have_first_ff <= 1'b0;
         total_ff      <= '0;
         sat_ff        <= 1'b0;
         first_x_ff    <= '0;
         first_y_ff    <= '0;
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
      end else begin
         if (cmd.load_city && !have_first_ff) begin
            have_first_ff <= 1'b1;
            total_ff      <= '0;
            sat_ff        <= 1'b0;
            first_x_ff    <= req_data.city_x;
            first_y_ff    <= req_data.city_y;
            prev_x_ff     <= req_data.city_x;
            prev_y_ff     <= req_data.city_y;
         end
         if (cmd.diff_en && !cmd.close_sel) begin
            prev_x_ff <= cur_x_ff;
            prev_y_ff <= cur_y_ff;
         end
         if (cmd.accum_en) begin
            total_ff <= total_in;
            sat_ff   <= sat_in;
         end
         if (cmd.out_load) begin
            have_first_ff <= 1'b0;
            total_ff      <= '0;
            sat_ff        <= 1'b0;
            first_x_ff    <= '0;
            first_y_ff    <= '0;
            prev_x_ff     <= '0;
            prev_y_ff     <= '0;
         end
      end
   end

   // Working registers of the edge computation.
   always_ff @(posedge clock) begin
      if (cmd.load_city) begin
         cur_x_ff <= req_data.city_x;
         cur_y_ff <= req_data.city_y;
         last_ff  <= req_data.last_city;
      end
      if (cmd.diff_en) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
      if (cmd.square_en) begin
         sx_ff <= dx_ff * dx_ff;
         sy_ff <= dy_ff * dy_ff;
      end
      if (cmd.sum_en) begin
         rad_ff  <= W'(sx_ff) + W'(sy_ff);
         rem_ff  <= '0;
         root_ff <= '0;
      end
      if (cmd.root_step) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
      if (cmd.out_load) begin
         rsp_ff.tour_length      <= total_ff;
         rsp_ff.length_saturated <= sat_ff;
      end
   end

   assign sts.have_first = have_first_ff;
   assign sts.last_city  = last_ff;
   assign rsp_data       = rsp_ff;

endmodule

// ===== rtl/ctl_ctrl.sv =====
`include "closed_tour_length_defines.svh"

module ctl_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_last_city,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  ctl_pkg::sts_type sts,
   output ctl_pkg::cmd_type cmd
);

   localparam int S = ctl_pkg::StepBits;

   ctl_pkg::state_type state_ff, state_in;
   logic               close_ff, close_in;
   logic [S-1:0]       step_ff, step_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               req_xfer, rsp_free;

   assign req_stall = (state_ff != ctl_pkg::ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   // State register and sequencing counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ctl_pkg::ST_IDLE;
         close_ff     <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         close_ff     <= close_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in      = state_ff;
      close_in      = close_ff;
      step_in       = step_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      cmd           = '0;
      cmd.close_sel = close_ff;
      case (state_ff)
         ctl_pkg::ST_IDLE: begin
            if (req_xfer) begin
               cmd.load_city = 1'b1;
               if (sts.have_first) begin
                  close_in = 1'b0;
                  state_in = ctl_pkg::ST_DIFF;
               end else if (req_last_city) begin
                  close_in = 1'b1;
                  state_in = ctl_pkg::ST_DIFF;
               end
            end
         end
         ctl_pkg::ST_DIFF: begin
            cmd.diff_en = 1'b1;
            state_in    = ctl_pkg::ST_SQUARE;
         end
         ctl_pkg::ST_SQUARE: begin
            cmd.square_en = 1'b1;
            state_in      = ctl_pkg::ST_SUM;
         end
         ctl_pkg::ST_SUM: begin
            cmd.sum_en = 1'b1;
            step_in    = S'(ctl_pkg::RootBits - 1);
            state_in   = ctl_pkg::ST_ROOT;
         end
         ctl_pkg::ST_ROOT: begin
            cmd.root_step = 1'b1;
            step_in       = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = ctl_pkg::ST_ACCUM;
            end
         end
         ctl_pkg::ST_ACCUM: begin
            cmd.accum_en = 1'b1;
            if (close_ff) begin
               state_in = ctl_pkg::ST_DONE;
            end else if (sts.last_city) begin
               close_in = 1'b1;
               state_in = ctl_pkg::ST_DIFF;
            end else begin
               state_in = ctl_pkg::ST_IDLE;
            end
         end
         ctl_pkg::ST_DONE: begin
            if (rsp_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               close_in     = 1'b0;
               state_in     = ctl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ctl_pkg::ST_IDLE;
         end
      endcase
   end

   // A result is only released after the closing edge has been added.
   `CTL_ASSERT_NOW(a_out_after_close, cmd.out_load, close_ff, "result without closing edge")
   // A waiting result is never overwritten by the next tour.
   `CTL_ASSERT_NOW(a_no_overwrite, cmd.out_load, rsp_free, "result register overwritten")
   // The last root step always hands over to the accumulate step.
   `CTL_ASSERT_NEXT(a_root_end, (state_ff == ctl_pkg::ST_ROOT) && (step_ff == '0),
                    state_ff == ctl_pkg::ST_ACCUM, "root iteration overran")
   // Loading the result register raises the output valid.
   `CTL_ASSERT_NEXT(a_out_valid, cmd.out_load, rsp_valid_ff, "loaded result not presented")

endmodule

// ===== rtl/closed_tour_length.sv =====
// Closed tour length: one city per transfer, Euclidean edges floored and summed.
// A first city that is not last is only stored. Every other city adds an edge in the
// difference, square, sum, restoring square root (one root bit per cycle) and
// accumulate steps. A last city adds the closing edge, the only one of a single-city
// tour. The result is presented once the output is free, when req_stall also drops.
// Reset (synchronous, active high) clears the tour state and drops any pending result.
module closed_tour_length (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ctl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ctl_pkg::rsp_type rsp_data
);

   ctl_pkg::cmd_type cmd;
   ctl_pkg::sts_type sts;

   // Sequencer for the per-city edge computation and output handoff.
   ctl_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_last_city (req_data.last_city),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .sts           (sts),
      .cmd           (cmd)
   );

   // Coordinate, square, root and accumulation registers.
   ctl_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule
